@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // command codes carried in tuser of the input word
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } t_cmd;

    // result status carried in tuser of the output word
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // control sequencer
    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_READ = 1'b1
    } t_state;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned OCC_W  = 5;

endpackage

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// Double-ended queue of bytes held in a ring buffer of DEPTH entries.
// Input channel (s_axis): tuser carries the command (push front, push rear,
// pop front, pop rear), tdata carries the byte to push; pops ignore it.
// Output channel (m_axis): one word per command. tdata carries the popped
// byte (zero for pushes and for a pop on an empty queue), the empty flag
// and the occupancy after the command; tuser carries the status (ok, pop
// on empty, push on full). A push into a full queue is dropped.
// Throughput: pushes and refused commands leave the sequencer idle, so one
// can be taken every cycle while the receiver keeps up. A successful pop
// passes through the read state while the registered read of the slot
// memory completes, and no new command is taken during that state.
// The result sits in an output register; a new command is taken while idle
// and that register is empty or being emptied in the same cycle, so a
// stalled receiver holds back the input after one waiting result.
// Reset clears the sequencer state, the head index, the entry count and the
// output valid; slot contents are undefined until pushed and are never read before that.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] item
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // result word
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,   // [7:0] data_out, [8] is_empty,
                                               // [13:9] occupancy, [15:14] zero
    output logic      [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = $clog2(2 * DEPTH);
    localparam int unsigned OW = deq_pkg::OCC_W;
    localparam int unsigned DW = deq_pkg::DATA_W;

    // control registers
    deq_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // result payload registers
    logic [DW-1:0]    r_out_data, n_out_data;
    deq_pkg::t_status r_out_status, n_out_status;
    logic             r_out_empty, n_out_empty;
    logic [OW-1:0]    r_out_occ, n_out_occ;

    // memory port signals
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [DW-1:0]    ram_rdata;

    logic             in_acc;
    deq_pkg::t_cmd    in_cmd;
    logic             is_full, is_empty_now;
    logic [AW-1:0]    head_dec, head_inc;
    logic [SW-1:0]    tail_sum, rear_sum;
    logic [AW-1:0]    rear_wr, rear_rd;
    logic [CW+OW-1:0] occ_ext;

    assign in_cmd       = deq_pkg::t_cmd'(i_s_axis_tuser);
    assign is_full      = (r_count == CW'(DEPTH));
    assign is_empty_now = (r_count == '0);

    // take a word while idle and the result register is free or draining
    assign o_s_axis_tready = (r_state == deq_pkg::SEQ_IDLE) &&
                             (!r_out_valid || i_m_axis_tready);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // ring index arithmetic, wrap by one compare and subtract
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign rear_sum = tail_sum - SW'(1);
    assign rear_wr  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign rear_rd  = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

    // occupancy is reported masked to its field width
    assign occ_ext = {{OW{1'b0}}, n_count};

    // sequencer: command decode, memory access and result build
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_empty  = r_out_empty;
        n_out_occ    = r_out_occ;
        ram_we       = 1'b0;
        ram_waddr    = rear_wr;
        ram_re       = 1'b0;
        ram_raddr    = r_head;

        unique case (r_state)
            deq_pkg::SEQ_IDLE: begin
                if (in_acc) begin
                    n_out_data   = '0;
                    n_out_status = deq_pkg::ST_OK;
                    n_out_valid  = 1'b1;
                    unique case (in_cmd)
                        deq_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                n_out_status = deq_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = head_dec;
                                n_head    = head_dec;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_PUSH_REAR: begin
                            if (is_full) begin
                                n_out_status = deq_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = rear_wr;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            if (is_empty_now) begin
                                n_out_status = deq_pkg::ST_EMPTY;
                            end else begin
                                ram_re      = 1'b1;
                                ram_raddr   = r_head;
                                n_head      = head_inc;
                                n_count     = r_count - CW'(1);
                                n_out_valid = 1'b0;
                                n_state     = deq_pkg::SEQ_READ;
                            end
                        end
                        deq_pkg::CMD_POP_REAR: begin
                            if (is_empty_now) begin
                                n_out_status = deq_pkg::ST_EMPTY;
                            end else begin
                                ram_re      = 1'b1;
                                ram_raddr   = rear_rd;
                                n_count     = r_count - CW'(1);
                                n_out_valid = 1'b0;
                                n_state     = deq_pkg::SEQ_READ;
                            end
                        end
                    endcase
                    n_out_empty = (n_count == '0);
                    n_out_occ   = occ_ext[OW-1:0];
                end
            end
            deq_pkg::SEQ_READ: begin
                // slot data arrives from the registered read in the cycle after the read
                n_out_data  = ram_rdata;
                n_out_valid = 1'b1;
                n_state     = deq_pkg::SEQ_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::SEQ_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_empty  <= n_out_empty;
        r_out_occ    <= n_out_occ;
    end

    // slot storage
    deq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_occ, r_out_empty, r_out_data};
    assign o_m_axis_tuser  = r_out_status;

    // count stays within the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond ring depth");

    // a successful push grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_full &&
         (in_cmd == deq_pkg::CMD_PUSH_FRONT || in_cmd == deq_pkg::CMD_PUSH_REAR))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the count");

    // a successful pop waits for the slot read, then presents its result
    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_empty_now &&
         (in_cmd == deq_pkg::CMD_POP_FRONT || in_cmd == deq_pkg::CMD_POP_REAR))
        |=> (r_state == deq_pkg::SEQ_READ && !r_out_valid) ##1 r_out_valid)
        else $error("pop result not presented after slot read");

    // no result is overwritten while the receiver stalls
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(o_m_axis_tdata)))
        else $error("waiting result lost or changed");

endmodule

`default_nettype wire

@@ rtl/deq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
